// ----- rtl/lir_pkg.sv -----
// Shared types, widths and codes of the linear interpolation resampler.
package lir_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int FRAC_BITS        = 20;
  localparam int MAX_OUT_PER_ITEM = 16;
  localparam int STEP_BITS        = 24;
  localparam int LEN_BITS         = 16;
  localparam int CNT_BITS         = 16;
  localparam int POS_BITS         = 40;
  localparam int POS_INT_BITS     = POS_BITS - FRAC_BITS;
  localparam int ITEM_CNT_BITS    = $clog2(MAX_OUT_PER_ITEM + 1);
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_BITS        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS        = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_DATA_BITS    = 32;
  localparam int APB_ADDR_BITS    = 3;

  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1048576);
  localparam logic [LEN_BITS-1:0]  LEN_RESET  = LEN_BITS'(512);
  localparam logic [CNT_BITS-1:0]  CNT_MAX    = {CNT_BITS{1'b1}};

  typedef enum logic {
    REG_STEP       = 1'b0,
    REG_OUT_LENGTH = 1'b1
  } reg_idx_t;

  typedef enum logic {
    CMD_INTERP,
    CMD_FINAL
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_res;
    logic                          run_last;
    logic                          ir_done;
    logic                          truncated;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t                     kind;
    logic signed [SAMPLE_BITS-1:0] prev;
    logic signed [SAMPLE_BITS-1:0] cur;
    logic [CNT_BITS-1:0]           n;
  } cmd_t;

endpackage

// ----- rtl/linear_interp_resampler_unit.sv -----
// Top level of the linear interpolation resampler with its register port.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid / in_stall   | in_item_t  (sample, last)
//  out     | output    | out_valid / out_stall | out_item_t (sample_res, flags)
//  apb     | input     | psel / penable        | step @ 0x0, out_length @ 0x4
//
// Each queued item is loaded into the engine from the idle state, then its
// results follow; the back engine, which issues one result per cycle while the
// output is not stalled, sets the pace. Items that yield nothing at the front
// (the first sample, a saturated count) are not queued. Reset is synchronous
// and active low; it clears all control state and restores the register reset
// values. A stalled output holds the result register; the front keeps taking
// transfers until the queue fills.
module linear_interp_resampler_unit
  import lir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [LEN_BITS-1:0]  out_length_r, out_length_nxt;
  logic                 cfg_wr;
  reg_idx_t             reg_idx;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_data;
  cmd_t q_head;

  // Register port: pready is tied high, word index taken from address bit 2.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    step_nxt       = step_r;
    out_length_nxt = out_length_r;
    prdata         = '0;
    unique case (reg_idx)
      REG_STEP: begin
        prdata = APB_DATA_BITS'(step_r);
        if (cfg_wr) begin
          step_nxt = pwdata[STEP_BITS-1:0];
        end
      end
      REG_OUT_LENGTH: begin
        prdata = APB_DATA_BITS'(out_length_r);
        if (cfg_wr) begin
          out_length_nxt = pwdata[LEN_BITS-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= STEP_RESET;
      out_length_r <= LEN_RESET;
    end else begin
      step_r       <= step_nxt;
      out_length_r <= out_length_nxt;
    end
  end

  // Front: take input transfers, keep previous sample and input count.
  lir_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  // Queue: decouple the input side from the output engine.
  lir_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back: advance the phase accumulator, interpolate, drive result transfers.
  lir_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step_r),
    .out_length (out_length_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/lir_queue.sv -----
// Short command queue between the front and the back of the resampler.
module lir_queue
  import lir_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t                 entries_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/lir_front.sv -----
// Input side: accept samples, track the input-side state, queue work commands.
module lir_front
  import lir_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_data
);

  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic signed [SAMPLE_BITS-1:0] prev_nxt;
  logic [CNT_BITS-1:0]           cnt_r;
  logic [CNT_BITS-1:0]           cnt_nxt;
  logic                          accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    q_data.kind = in_data.last ? CMD_FINAL : CMD_INTERP;
    q_data.prev = prev_r;
    q_data.cur  = in_data.sample;
    q_data.n    = cnt_r;
    // drop the first sample and anything past a saturated count, unless it is last
    q_push      = accept && (in_data.last || (cnt_r != '0 && cnt_r != CNT_MAX));
    prev_nxt    = prev_r;
    cnt_nxt     = cnt_r;
    if (accept) begin
      if (in_data.last) begin
        prev_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        prev_nxt = in_data.sample;
        cnt_nxt  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      cnt_r  <= '0;
    end else begin
      prev_r <= prev_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/lir_back.sv -----
// Output engine: step the phase accumulator and emit one result per cycle while the output is not stalled.
module lir_back
  import lir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [STEP_BITS-1:0] step,
  input  logic [LEN_BITS-1:0]  out_length,
  input  logic                 q_empty,
  input  cmd_t                 q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  bk_state_t                  state_r, state_nxt;
  cmd_t                       cmd_r, cmd_nxt;
  logic [ITEM_CNT_BITS-1:0]   k_r, k_nxt;
  logic [POS_BITS-1:0]        pos_r, pos_nxt;
  logic [LEN_BITS-1:0]        oc_r, oc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_data_r, out_data_nxt;

  logic [POS_INT_BITS-1:0]        pos_int;
  logic [FRAC_BITS-1:0]           frac;
  logic [POS_BITS-1:0]            pos_add;
  logic [CNT_BITS-1:0]            nm1;
  logic [POS_INT_BITS-1:0]        n_ext;
  logic [POS_INT_BITS-1:0]        nm1_ext;
  logic                           is_final;
  logic                           cont;
  logic                           nxt_cont;
  logic                           nlen_ok;
  logic                           nidx;
  logic                           trunc;
  logic                           slot_free;
  logic                           emit;
  logic [LEN_BITS-1:0]            oc_inc;
  logic [ITEM_CNT_BITS-1:0]       k_inc;
  logic signed [SAMPLE_BITS:0]    diff;
  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod;
  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] quot;
  logic signed [SAMPLE_BITS-1:0]  interp_val;
  logic signed [SAMPLE_BITS-1:0]  value;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // interpolation: prev + floor((cur - prev) * frac / 2^FRAC_BITS)
  always_comb begin
    diff       = $signed({cmd_r.cur[SAMPLE_BITS-1], cmd_r.cur})
               - $signed({cmd_r.prev[SAMPLE_BITS-1], cmd_r.prev});
    prod       = diff * $signed({1'b0, frac});
    quot       = prod >>> FRAC_BITS;
    interp_val = cmd_r.prev + quot[SAMPLE_BITS-1:0];
  end

  always_comb begin
    pos_int   = pos_r[POS_BITS-1:FRAC_BITS];
    frac      = pos_r[FRAC_BITS-1:0];
    pos_add   = pos_r + POS_BITS'(step);
    nm1       = cmd_r.n - 1'b1;
    n_ext     = POS_INT_BITS'(cmd_r.n);
    nm1_ext   = POS_INT_BITS'(nm1);
    is_final  = (cmd_r.kind == CMD_FINAL);
    oc_inc    = oc_r + 1'b1;
    k_inc     = k_r + 1'b1;
    slot_free = !out_valid_r || !out_stall;

    cont     = (k_r < ITEM_CNT_BITS'(MAX_OUT_PER_ITEM)) && (oc_r < out_length)
            && (is_final || pos_int == nm1_ext);
    nlen_ok  = (oc_inc < out_length);
    nidx     = (pos_add[POS_BITS-1:FRAC_BITS] == nm1_ext);
    nxt_cont = (k_inc < ITEM_CNT_BITS'(MAX_OUT_PER_ITEM)) && nlen_ok
            && (is_final || nidx);
    trunc    = is_final ? nlen_ok : (nlen_ok && nidx);

    if (!is_final) begin
      value = interp_val;
    end else if (cmd_r.n != '0 && pos_int == nm1_ext) begin
      value = interp_val;
    end else if (pos_int == n_ext) begin
      value = cmd_r.cur;
    end else if (pos_int > n_ext) begin
      value = '0;
    end else begin
      value = cmd_r.prev;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    k_nxt        = k_r;
    pos_nxt      = pos_r;
    oc_nxt       = oc_r;
    out_data_nxt = out_data_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          k_nxt     = '0;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!cont) begin
          state_nxt = BK_IDLE;
          if (is_final) begin
            pos_nxt = '0;
            oc_nxt  = '0;
          end
        end else if (slot_free) begin
          emit                   = 1'b1;
          out_data_nxt.sample_res = value;
          out_data_nxt.run_last  = !nxt_cont;
          out_data_nxt.ir_done   = is_final && !nxt_cont;
          out_data_nxt.truncated = !nxt_cont && trunc;
          oc_nxt                 = oc_inc;
          k_nxt                  = k_inc;
          pos_nxt                = pos_add;
          if (!nxt_cont) begin
            state_nxt = BK_IDLE;
            if (is_final) begin
              pos_nxt = '0;
              oc_nxt  = '0;
            end else if (trunc) begin
              // jump to the start of the next input interval
              pos_nxt = {n_ext, {FRAC_BITS{1'b0}}};
            end
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      k_r         <= '0;
      pos_r       <= '0;
      oc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      pos_r       <= pos_nxt;
      oc_r        <= oc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= ITEM_CNT_BITS'(MAX_OUT_PER_ITEM))
    else $error("per-item result count exceeds cap");

  a_emit_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (state_r == BK_RUN))
    else $error("result emitted outside run state");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.ir_done || out_data_r.truncated)) |-> out_data_r.run_last)
    else $error("end flag without run_last");

  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN && cmd_r.kind == CMD_FINAL && state_nxt == BK_IDLE)
      |=> (pos_r == '0 && oc_r == '0))
    else $error("response end did not clear position and count");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the linear interpolation resampler: stimulus, prediction, checks.
module tb
  import lir_pkg::*;
();

  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 40;      // queue of four plus engine and output register
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off, fills the item queue
  localparam int RANDOM_ITEMS  = 170;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Tracks the resampler state per accepted sample and holds the results still due.
  class resample_board;
    logic [STEP_BITS-1:0]          step;
    logic [LEN_BITS-1:0]           out_len;
    logic signed [SAMPLE_BITS-1:0] prev_smp;
    logic [CNT_BITS-1:0]           in_cnt;
    logic [POS_BITS-1:0]           pos;
    logic [LEN_BITS-1:0]           out_cnt;
    out_item_t                     due_samples[$];
    int                            fails;

    function new();
      step     = STEP_RESET;
      out_len  = LEN_RESET;
      prev_smp = '0;
      in_cnt   = '0;
      pos      = '0;
      out_cnt  = '0;
      fails    = 0;
    endfunction

    function void apply_write(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
      if (idx == REG_STEP) step = value[STEP_BITS-1:0];
      else out_len = value[LEN_BITS-1:0];
    endfunction

    // a + floor((b - a) * frac / 2^FRAC_BITS)
    function logic signed [SAMPLE_BITS-1:0] lerp(logic signed [SAMPLE_BITS-1:0] a,
                                                 logic signed [SAMPLE_BITS-1:0] b,
                                                 logic [FRAC_BITS-1:0] frac);
      longint prod;
      prod = (longint'(b) - longint'(a)) * longint'(frac);
      return SAMPLE_BITS'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    function void note_sample(in_item_t it);
      out_item_t                     batch[MAX_OUT_PER_ITEM];
      int                            k;
      bit                            trunc;
      logic [31:0]                   pint;
      logic [31:0]                   n;
      logic signed [SAMPLE_BITS-1:0] v;
      k     = 0;
      trunc = 0;
      n     = 32'(in_cnt);
      if (!it.last) begin
        if (in_cnt >= 1 && in_cnt < CNT_MAX) begin
          // interpolate inside interval n-1 until the position leaves it
          while (k < MAX_OUT_PER_ITEM && out_cnt < out_len &&
                 32'(pos >> FRAC_BITS) == n - 1) begin
            batch[k] = '{sample_res: lerp(prev_smp, it.sample, pos[FRAC_BITS-1:0]),
                         default: 1'b0};
            k++;
            out_cnt++;
            pos = pos + POS_BITS'(step);
          end
          // cap hit with outputs still due here: jump to the next interval
          if (out_cnt < out_len && 32'(pos >> FRAC_BITS) == n - 1) begin
            pos   = POS_BITS'(in_cnt) << FRAC_BITS;
            trunc = 1;
          end
        end
        prev_smp = it.sample;
        if (in_cnt < CNT_MAX) in_cnt++;
      end else begin
        while (k < MAX_OUT_PER_ITEM && out_cnt < out_len) begin
          pint = 32'(pos >> FRAC_BITS);
          if (n >= 1 && pint + 1 == n) v = lerp(prev_smp, it.sample, pos[FRAC_BITS-1:0]);
          else if (pint == n) v = it.sample;
          else if (pint > n) v = '0;
          else v = prev_smp;
          batch[k] = '{sample_res: v, default: 1'b0};
          k++;
          out_cnt++;
          pos = pos + POS_BITS'(step);
        end
        trunc    = (out_cnt < out_len);
        prev_smp = '0;
        in_cnt   = '0;
        pos      = '0;
        out_cnt  = '0;
      end
      if (k > 0) begin
        batch[k-1].run_last  = 1'b1;
        batch[k-1].ir_done   = it.last;
        batch[k-1].truncated = trunc;
      end
      for (int i = 0; i < k; i++) due_samples.push_back(batch[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_samples.size() == 0) begin
        $error("unexpected result: sample_res %0d", got.sample_res);
        fails++;
        return;
      end
      want = due_samples.pop_front();
      if (got.sample_res !== want.sample_res) begin
        $error("sample_res: expected %0d, got %0d", want.sample_res, got.sample_res);
        fails++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
        fails++;
      end
      if (got.ir_done !== want.ir_done) begin
        $error("ir_done: expected %0d, got %0d", want.ir_done, got.ir_done);
        fails++;
      end
      if (got.truncated !== want.truncated) begin
        $error("truncated: expected %0d, got %0d", want.truncated, got.truncated);
        fails++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  resample_board board;
  int            cycle_cnt = 0;
  bit            no_idle   = 0;  // suppress random gaps on both sides
  bit            hold_req  = 0;  // ask the receiver for one long hold-off

  linear_interp_resampler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Timeout: a hung handshake or missing results end the run here.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk) cycle_cnt++;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stall at the falling edge, one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 17);
      end
    end
  end

  // Check every result transfer at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return '0;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // Offer one sample, with random gaps ahead of it; hold it until the transfer.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
    in_item_t it;
    it.sample = smp;
    it.last   = last;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(it);
  endtask

  // Drop valid, wait for every due result, then let queued no-result items retire.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, done at the edge with pready high.
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(int'(idx) * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.apply_write(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [STEP_BITS-1:0] step, input logic [LEN_BITS-1:0] len);
    drain();
    write_reg(REG_STEP, APB_DATA_BITS'(step));
    write_reg(REG_OUT_LENGTH, APB_DATA_BITS'(len));
  endtask

  initial begin
    int                   items_sent;
    int                   ir_num;
    int                   len;
    logic [STEP_BITS-1:0] step;
    logic [LEN_BITS-1:0]  olen;
    board    = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers, unit step. A lone last item: held sample, then the zero
    // tail cut by the per-item cap.
    send_sample(SMP_MAX, 1'b1);
    // First sample yields nothing; full-scale swings between the extremes.
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b1);

    // Lowest step: eight outputs per interval, longest response. Hold the
    // receiver off meanwhile so the queue fills and the input stalls.
    configure(STEP_BITS'(131072), LEN_BITS'(65535));
    hold_req = 1;
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SAMPLE_BITS'(12345), 1'b0);
    for (int i = 0; i < 8; i++) send_sample(rand_sample(), 1'b0);
    send_sample(-SAMPLE_BITS'(1), 1'b1);

    // Zero step: the cap truncates the first interval, then the output count is
    // reached and the last item brings no done flag.
    configure('0, LEN_BITS'(20));
    send_sample(SAMPLE_BITS'(100), 1'b0);
    send_sample(-SAMPLE_BITS'(100), 1'b0);
    send_sample(SAMPLE_BITS'(5), 1'b0);
    send_sample(SAMPLE_BITS'(7), 1'b1);

    // Highest step in range: most intervals yield nothing.
    configure(STEP_BITS'(8388608), LEN_BITS'(65535));
    for (int i = 0; i < 6; i++) send_sample(rand_sample(), i == 5);

    // No outputs at all, with the widest step.
    configure({STEP_BITS{1'b1}}, '0);
    for (int i = 0; i < 3; i++) send_sample(rand_sample(), i == 2);

    // Random responses, reconfigured every third one.
    items_sent = 0;
    ir_num     = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (ir_num % 3 == 0) begin
        case ($urandom_range(0, 9))
          0:       step = '0;
          1:       step = {STEP_BITS{1'b1}};
          2:       step = STEP_BITS'(131072);
          3:       step = STEP_BITS'(8388608);
          4, 5, 6: step = STEP_BITS'($urandom_range(131072, 1048576));
          default: step = STEP_BITS'($urandom_range(1048576, 8388608));
        endcase
        case ($urandom_range(0, 9))
          0:       olen = '0;
          1:       olen = LEN_BITS'(65535);
          2, 3:    olen = LEN_BITS'($urandom_range(1, 8));
          default: olen = LEN_BITS'($urandom_range(16, 300));
        endcase
        configure(step, olen);
      end
      no_idle = (ir_num >= 8 && ir_num < 16);
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
      for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
      items_sent += len;
      ir_num++;
    end
    no_idle = 0;

    drain();
    if (board.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
